[sv/teds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teds_pkg - shared types and constants for the touch event decoder/scaler
// Event kinds, register indexes, divider sizing and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package teds_pkg;

	// combined type/code words (type in low half, code in high half)
	localparam logic [31:0] KIND_KEY = 32'h014A_0001;
	localparam logic [31:0] KIND_Y   = 32'h0000_0003;
	localparam logic [31:0] KIND_X   = 32'h0001_0003;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_X_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

	localparam logic [15:0] RST_X_MIN  = 16'd70;
	localparam logic [15:0] RST_X_MAX  = 16'd4000;
	localparam logic [15:0] RST_Y_MIN  = 16'd70;
	localparam logic [15:0] RST_Y_MAX  = 16'd4000;
	localparam logic [15:0] RST_WIDTH  = 16'd1024;
	localparam logic [15:0] RST_HEIGHT = 16'd600;

	// Quotients of 2^17 and up always saturate, so only 17 quotient bits
	// are developed; the upper numerator bits only feed an overflow check.
	localparam int unsigned DIV_STEPS = 17;
	localparam int unsigned CNT_W     = 5;

	typedef struct packed {
		logic accept;    // input request taken this cycle
		logic sel_y;     // 0: X axis pass, 1: Y axis pass
		logic mul;       // register product and range flags
		logic init;      // load divider, overflow check
		logic step;      // one restoring division step
		logic fin;       // clamp quotient into axis result
		logic load_out;  // move results into output register
	} dp_cmd_t;

	typedef struct packed {
		logic key_on;
		logic key_off;
		logic pressed;
	} dp_sts_t;

endpackage

[sv/teds_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teds_dpath - datapath of the touch event decoder/scaler
// Config registers, pen/raw state, 16x32 multiply, shared restoring divider,
// saturation and the result output register.
// ----------------------------------------------------------------------------
module teds_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [teds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic [31:0]                   event_kind,
	input  logic [31:0]                   event_value,
	input  teds_pkg::dp_cmd_t             cmd,
	output teds_pkg::dp_sts_t             sts,
	output logic                          pen_down,
	output logic [15:0]                   screen_x,
	output logic [15:0]                   screen_y
);

	logic [15:0] x_min_q, x_max_q, y_min_q, y_max_q, width_q, height_q;
	logic        pressed_q;
	logic [31:0] raw_x_q, raw_y_q;

	logic [47:0] prod_q;
	logic [15:0] div_q;
	logic        le_min_q, bad_q, ovf_q;
	logic [15:0] rem_q;
	logic [16:0] lo_q, quot_q;
	logic [15:0] res_x_q, res_y_q;

	logic        is_key, key_on, key_off;
	logic [31:0] raw_sel;
	logic [15:0] min_sel, max_sel, scale_sel, top;
	logic [31:0] diff;
	logic [30:0] hi;
	logic [16:0] trial, trial_sub;
	logic        take;
	logic [15:0] x_fin, y_fin;

	assign is_key  = (event_kind == teds_pkg::KIND_KEY);
	assign key_on  = is_key && (event_value == 32'd1);
	assign key_off = is_key && (event_value == 32'd0);
	assign sts     = '{key_on: key_on, key_off: key_off, pressed: pressed_q};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q  <= teds_pkg::RST_X_MIN;
			x_max_q  <= teds_pkg::RST_X_MAX;
			y_min_q  <= teds_pkg::RST_Y_MIN;
			y_max_q  <= teds_pkg::RST_Y_MAX;
			width_q  <= teds_pkg::RST_WIDTH;
			height_q <= teds_pkg::RST_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				teds_pkg::REG_X_MIN:  x_min_q  <= cfg_data;
				teds_pkg::REG_X_MAX:  x_max_q  <= cfg_data;
				teds_pkg::REG_Y_MIN:  y_min_q  <= cfg_data;
				teds_pkg::REG_Y_MAX:  y_max_q  <= cfg_data;
				teds_pkg::REG_WIDTH:  width_q  <= cfg_data;
				teds_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pen state and latched raw readings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			raw_x_q   <= '0;
			raw_y_q   <= '0;
		end else if (cmd.accept) begin
			if (key_on) begin
				pressed_q <= 1'b1;
			end else if (key_off) begin
				pressed_q <= 1'b0;
			end else if (pressed_q) begin
				if (event_kind == teds_pkg::KIND_Y) begin
					raw_y_q <= event_value;
				end else if (event_kind == teds_pkg::KIND_X) begin
					raw_x_q <= event_value;
				end
			end
		end
	end

	// axis select for the current pass
	assign raw_sel   = cmd.sel_y ? raw_y_q  : raw_x_q;
	assign min_sel   = cmd.sel_y ? y_min_q  : x_min_q;
	assign max_sel   = cmd.sel_y ? y_max_q  : x_max_q;
	assign scale_sel = cmd.sel_y ? height_q : width_q;
	assign diff      = raw_sel - {16'd0, min_sel};

	assign hi        = prod_q[47:17];
	assign trial     = {rem_q, lo_q[16]};
	assign trial_sub = trial - {1'b0, div_q};
	assign take      = (trial >= {1'b0, div_q});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q   <= {32'd0, scale_sel} * {16'd0, diff};
			div_q    <= max_sel - min_sel;
			le_min_q <= (raw_sel <= {16'd0, min_sel});
			bad_q    <= (max_sel <= min_sel);
		end
		if (cmd.init) begin
			ovf_q  <= (hi >= {15'd0, div_q});
			rem_q  <= hi[15:0];
			lo_q   <= prod_q[16:0];
			quot_q <= '0;
		end
		if (cmd.step) begin
			rem_q  <= take ? trial_sub[15:0] : trial[15:0];
			lo_q   <= {lo_q[15:0], 1'b0};
			quot_q <= {quot_q[15:0], take};
		end
		if (cmd.fin) begin
			if (cmd.sel_y) begin
				res_y_q <= y_fin;
			end else begin
				res_x_q <= x_fin;
			end
		end
		if (cmd.load_out) begin
			pen_down <= pressed_q;
			screen_x <= res_x_q;
			screen_y <= res_y_q;
		end
	end

	// X saturates at width; Y counts down from top and floors at zero
	assign top = (height_q == 16'd0) ? 16'd0 : height_q - 16'd1;

	always_comb begin
		if (le_min_q || bad_q) begin
			x_fin = 16'd0;
		end else if (ovf_q || (quot_q > {1'b0, width_q})) begin
			x_fin = width_q;
		end else begin
			x_fin = quot_q[15:0];
		end

		if (le_min_q) begin
			y_fin = top;
		end else if (bad_q || ovf_q || (quot_q >= {1'b0, top})) begin
			y_fin = 16'd0;
		end else begin
			y_fin = top - quot_q[15:0];
		end
	end

endmodule

[sv/teds_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teds_ctrl - sequencer of the touch event decoder/scaler
// Takes requests, runs the X then Y scaling passes over the shared divider
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module teds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	output logic              evt_stall,
	output logic              res_valid,
	input  logic              res_stall,
	input  teds_pkg::dp_sts_t sts,
	output teds_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_INIT = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	localparam logic [teds_pkg::CNT_W-1:0] CNT_LAST = teds_pkg::CNT_W'(teds_pkg::DIV_STEPS - 1);

	logic [2:0]                 state_q;
	logic [teds_pkg::CNT_W-1:0] cnt_q;
	logic                       sel_q;
	logic                       out_valid_q;
	logic                       accept, emit, out_free;

	assign evt_stall = (state_q != ST_IDLE);
	assign accept    = evt_valid && !evt_stall;
	assign emit      = sts.key_on || sts.key_off || sts.pressed;
	assign out_free  = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = accept;
		cmd.sel_y    = sel_q;
		cmd.mul      = (state_q == ST_MUL);
		cmd.init     = (state_q == ST_INIT);
		cmd.step     = (state_q == ST_DIV);
		cmd.fin      = (state_q == ST_FIN);
		cmd.load_out = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sel_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					sel_q <= 1'b0;
					if (accept && emit) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + teds_pkg::CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (sel_q) begin
						state_q <= ST_OUT;
					end else begin
						sel_q   <= 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_emit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> (state_q == ST_MUL && !sel_q))
		else $error("emitting request did not start the X pass");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_LAST) |=> (state_q == ST_FIN))
		else $error("divider did not finish after its last step");

	a_y_after_x: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !sel_q) |=> (state_q == ST_MUL && sel_q))
		else $error("Y pass did not follow the X pass");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_stall) |=> (out_valid_q && !$past(cmd.load_out)))
		else $error("stalled result dropped or overwritten");

endmodule

[sv/touch_event_decoder_scaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_event_decoder_scaler - touch event decoder with linear calibration
// Tracks pen state from key events, latches raw X/Y axis readings while the
// pen is down and reports pen state with calibrated screen coordinates.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  -----------------------------------------
//  evt      evt_valid/evt_stall  event_kind[31:0], event_value[31:0]
//  res      res_valid/res_stall  pen_down, screen_x[15:0], screen_y[15:0]
//  cfg      cfg_valid/cfg_ready  cfg_index[2:0], cfg_data[15:0]
//
//  An event that reports nothing leaves the sequencer idle. One that reports
//  stalls further events while it runs: accept, then per axis one multiply,
//  one divider load, 17 divide steps on the shared restoring divider and one
//  clamp, then the output load. The output register holds a stalled result
//  while the next event is taken. Reset restores the calibration defaults,
//  releases the pen and zeroes the raw X/Y readings. cfg writes are always
//  ready; the user must make them while the block is idle; it does not check.
//
module touch_event_decoder_scaler (
	input  logic                           clk,
	input  logic                           arst_n,

	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [teds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,

	// event requests
	input  logic                           evt_valid,
	output logic                           evt_stall,
	input  logic [31:0]                    event_kind,
	input  logic [31:0]                    event_value,

	// result requests
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic                           pen_down,
	output logic [15:0]                    screen_x,
	output logic [15:0]                    screen_y
);

	teds_pkg::dp_cmd_t cmd;
	teds_pkg::dp_sts_t sts;

	// register file is a plain write port, never busy
	assign cfg_ready = 1'b1;

	// sequencer: request acceptance, X/Y passes, output valid
	teds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: config, pen/raw state, multiply, divide, clamp, output reg
	teds_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.event_kind  (event_kind),
		.event_value (event_value),
		.cmd         (cmd),
		.sts         (sts),
		.pen_down    (pen_down),
		.screen_x    (screen_x),
		.screen_y    (screen_y)
	);

endmodule

[test/tb_touch_event_decoder_scaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_event_decoder_scaler - self-checking bench for the touch decoder
// Streams touch event requests through the block under random sender idle
// and receiver stall. A local predictor tracks pen state, raw readings and
// calibration, and every result request is checked against it in order.
// Calibration is reloaded between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_touch_event_decoder_scaler;

	localparam int unsigned SETTLE_CYCLES   = 60;   // covers the report path of the last event
	localparam int unsigned QUIET_LIMIT     = 4000; // cycles with no request moving
	localparam int unsigned HOLD_CYCLES     = 400;  // long receiver back-pressure
	localparam int unsigned ITEMS_PER_PHASE = 140;
	localparam int unsigned NUM_PHASES      = 8;
	localparam int unsigned MAX_PRINTED     = 100;

	typedef struct packed {
		logic [31:0] kind;
		logic [31:0] value;
	} touch_evt_t;

	typedef struct packed {
		logic        pen;
		logic [15:0] x;
		logic [15:0] y;
	} touch_report_t;

	// block ports
	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [teds_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]                    cfg_data = '0;
	logic                           evt_valid = 1'b0;
	logic                           evt_stall;
	logic [31:0]                    event_kind = '0;
	logic [31:0]                    event_value = '0;
	logic                           res_valid;
	logic                           res_stall = 1'b0;
	logic                           pen_down;
	logic [15:0]                    screen_x;
	logic [15:0]                    screen_y;

	// stimulus and scoreboard
	touch_evt_t    pending_events[$];
	touch_report_t reports_due[$];
	touch_evt_t    next_evt;
	touch_report_t want;
	int unsigned   burst_items;
	int unsigned   error_count = 0;
	int unsigned   send_idle_pct = 0;
	int unsigned   stall_pct = 0;
	int unsigned   quiet_cycles = 0;
	int unsigned   hold_left = 0;
	logic          hold_req = 1'b0;
	logic          hold_taken = 1'b0;

	// raw ranges used to shape axis readings (set with each calibration)
	logic [15:0] span_x_lo = teds_pkg::RST_X_MIN, span_x_hi = teds_pkg::RST_X_MAX;
	logic [15:0] span_y_lo = teds_pkg::RST_Y_MIN, span_y_hi = teds_pkg::RST_Y_MAX;

	// predictor copy of calibration and pen/axis state
	logic [15:0] cal_x_min, cal_x_max, cal_y_min, cal_y_max, cal_width, cal_height;
	logic        pen_state;
	logic [31:0] raw_x_seen, raw_y_seen;

	touch_event_decoder_scaler dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.evt_valid  (evt_valid),
		.evt_stall  (evt_stall),
		.event_kind (event_kind),
		.event_value(event_value),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.pen_down   (pen_down),
		.screen_x   (screen_x),
		.screen_y   (screen_y)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Calibration math
	// ------------------------------------------------------------------

	// X: linear onto 0..width, zero at or below min or on an empty range,
	// saturated at width
	function automatic logic [15:0] calib_x();
		logic [63:0] num, den, q;
		if (raw_x_seen <= {16'd0, cal_x_min} || cal_x_max <= cal_x_min)
			return 16'd0;
		num = 64'(raw_x_seen);
		num = (num - 64'(cal_x_min)) * 64'(cal_width);
		den = 64'(cal_x_max) - 64'(cal_x_min);
		q = num / den;
		if (q > 64'(cal_width))
			q = 64'(cal_width);
		return q[15:0];
	endfunction

	// Y: inverted onto height-1..0; at or below min gives the top row,
	// an empty range gives 0, and the subtraction floors at 0
	function automatic logic [15:0] calib_y();
		logic [63:0] num, den, t;
		logic [15:0] top;
		top = (cal_height != 16'd0) ? cal_height - 16'd1 : 16'd0;
		if (raw_y_seen <= {16'd0, cal_y_min})
			return top;
		if (cal_y_max <= cal_y_min)
			return 16'd0;
		num = 64'(raw_y_seen);
		num = (num - 64'(cal_y_min)) * 64'(cal_height);
		den = 64'(cal_y_max) - 64'(cal_y_min);
		t = num / den;
		if (t >= 64'(top))
			return 16'd0;
		return top - t[15:0];
	endfunction

	// Advance pen/axis state for one accepted event and queue its report, if any.
	function automatic void predict_touch(input logic [31:0] kind, input logic [31:0] value);
		touch_report_t r;
		logic          emits;
		emits = 1'b0;
		r.pen = 1'b0;
		if (kind == teds_pkg::KIND_KEY && value == 32'd1)
			pen_state = 1'b1;
		if (kind == teds_pkg::KIND_KEY && value == 32'd0) begin
			// release always reports, even if already released
			pen_state = 1'b0;
			emits = 1'b1;
		end else if (pen_state) begin
			if (kind == teds_pkg::KIND_Y)
				raw_y_seen = value;
			else if (kind == teds_pkg::KIND_X)
				raw_x_seen = value;
			emits = 1'b1;
			r.pen = 1'b1;
		end
		if (emits) begin
			r.x = calib_x();
			r.y = calib_y();
			reports_due.push_back(r);
		end
	endfunction

	task automatic report_mismatch(input string what);
		if (error_count < MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $time, what);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Stimulus shaping
	// ------------------------------------------------------------------

	function automatic void queue_event(input logic [31:0] kind, input logic [31:0] value);
		touch_evt_t e;
		e.kind = kind;
		e.value = value;
		pending_events.push_back(e);
	endfunction

	// Raw axis reading: mostly around the calibrated span, with edges and
	// full-width values mixed in.
	function automatic logic [31:0] raw_reading(input logic [15:0] lo, input logic [15:0] hi);
		logic [31:0] a, b;
		a = (lo < hi) ? {16'd0, lo} : {16'd0, hi};
		b = (lo < hi) ? {16'd0, hi} : {16'd0, lo};
		case ($urandom_range(11))
			0:       return a;
			1:       return b;
			2:       return a + 32'd1;
			3:       return b + 32'd1;
			4, 5:    return $urandom;
			6:       return $urandom_range(65535);
			default: return $urandom_range(b + 200, (a > 200) ? a - 200 : 0);
		endcase
	endfunction

	// Kinds the decoder must not act on (a bit flip may land on a real one)
	function automatic logic [31:0] odd_kind();
		case ($urandom_range(3))
			0:       return $urandom;
			1:       return teds_pkg::KIND_KEY ^ (32'd1 << $urandom_range(31));
			2:       return teds_pkg::KIND_X ^ (32'd1 << $urandom_range(31));
			default: return teds_pkg::KIND_Y ^ (32'd1 << $urandom_range(31));
		endcase
	endfunction

	// press, a run of moves, usually a release
	task automatic queue_touch_burst();
		int unsigned moves;
		moves = $urandom_range(1, 8);
		queue_event(teds_pkg::KIND_KEY, 32'd1);
		repeat (moves) begin
			case ($urandom_range(9))
				0:       queue_event(odd_kind(), $urandom);
				1:       queue_event(teds_pkg::KIND_KEY, $urandom_range(2, 255));
				2:       queue_event(teds_pkg::KIND_KEY, 32'd1);
				3, 4, 5: queue_event(teds_pkg::KIND_X, raw_reading(span_x_lo, span_x_hi));
				default: queue_event(teds_pkg::KIND_Y, raw_reading(span_y_lo, span_y_hi));
			endcase
		end
		if ($urandom_range(99) < 85) begin
			queue_event(teds_pkg::KIND_KEY, 32'd0);
			burst_items += moves + 2;
		end else begin
			burst_items += moves + 1;
		end
	endtask

	// stray traffic between touches
	task automatic queue_noise();
		case ($urandom_range(4))
			0:       queue_event(teds_pkg::KIND_X, raw_reading(span_x_lo, span_x_hi));
			1:       queue_event(teds_pkg::KIND_Y, raw_reading(span_y_lo, span_y_hi));
			2:       queue_event(teds_pkg::KIND_KEY, 32'd0);
			3:       queue_event(teds_pkg::KIND_KEY, $urandom);
			default: queue_event(odd_kind(), $urandom);
		endcase
		burst_items += 1;
	endtask

	// ------------------------------------------------------------------
	// Configuration writes (called at a rising edge)
	// ------------------------------------------------------------------

	task automatic write_reg(input logic [teds_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
	endtask

	task automatic load_calibration(input logic [15:0] x_min, input logic [15:0] x_max,
			input logic [15:0] y_min, input logic [15:0] y_max,
			input logic [15:0] width, input logic [15:0] height);
		write_reg(teds_pkg::REG_X_MIN, x_min);
		write_reg(teds_pkg::REG_X_MAX, x_max);
		write_reg(teds_pkg::REG_Y_MIN, y_min);
		write_reg(teds_pkg::REG_Y_MAX, y_max);
		write_reg(teds_pkg::REG_WIDTH, width);
		write_reg(teds_pkg::REG_HEIGHT, height);
		cfg_valid <= 1'b0;
		span_x_lo = x_min;
		span_x_hi = x_max;
		span_y_lo = y_min;
		span_y_hi = y_max;
	endtask

	// all requests sent, all reports back, then let the last event settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_events.size() != 0 || evt_valid || reports_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		logic [15:0] lo_x, lo_y;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset calibration (70..4000, 1024 x 600)
		send_idle_pct = 33;
		stall_pct = 64;
		queue_event(teds_pkg::KIND_X, 32'd500);         // axis while released: ignored
		queue_event(teds_pkg::KIND_KEY, 32'd0);         // release while released still reports
		queue_event(teds_pkg::KIND_KEY, 32'hFFFF_FFFF); // odd key value while released: nothing
		queue_event(teds_pkg::KIND_KEY, 32'd1);         // press reports too
		queue_event(teds_pkg::KIND_X, 32'd0);
		queue_event(teds_pkg::KIND_X, 32'd70);          // at min
		queue_event(teds_pkg::KIND_X, 32'd71);
		queue_event(teds_pkg::KIND_X, 32'd4000);        // full width
		queue_event(teds_pkg::KIND_X, 32'd4001);        // saturates
		queue_event(teds_pkg::KIND_X, 32'hFFFF_FFFF);
		queue_event(teds_pkg::KIND_Y, 32'd0);
		queue_event(teds_pkg::KIND_Y, 32'd70);          // top row
		queue_event(teds_pkg::KIND_Y, 32'd71);
		queue_event(teds_pkg::KIND_Y, 32'd4000);        // floors at 0
		queue_event(teds_pkg::KIND_Y, 32'hFFFF_FFFF);
		queue_event(32'hFFFF_FFFF, 32'h5555_AAAA);      // unknown kind while pressed
		queue_event(32'h0000_0000, 32'hAAAA_5555);
		queue_event(teds_pkg::KIND_KEY ^ 32'h8000_0000, 32'd0);
		queue_event(teds_pkg::KIND_KEY, 32'd2);         // odd key value while pressed
		queue_event(teds_pkg::KIND_KEY, 32'd1);         // press while pressed
		queue_event(teds_pkg::KIND_KEY, 32'd0);
		queue_event(teds_pkg::KIND_Y, 32'd123);         // ignored again
		queue_event(teds_pkg::KIND_KEY, 32'd0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			@(posedge clk);
			case (p)
				0: load_calibration(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				1: load_calibration(16'd1000, 16'd1010, 16'd2000, 16'd2003, 16'd1024, 16'd768);
				2: load_calibration(16'd5000, 16'd100, 16'd5000, 16'd100, 16'd800, 16'd480);
				3: load_calibration(16'd1000, 16'd1000, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
				4: load_calibration(16'd70, 16'd4000, 16'd70, 16'd4000, 16'd0, 16'd0);
				default: begin
					lo_x = 16'($urandom_range(30000));
					lo_y = 16'($urandom_range(30000));
					load_calibration(lo_x, lo_x + 16'($urandom_range(1, 30000)),
						lo_y, lo_y + 16'($urandom_range(1, 30000)),
						16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
				end
			endcase
			@(negedge clk);

			// receiver-heavy stalling, then sender-heavy idling, then none
			if (p < 3) begin
				send_idle_pct = 33;
				stall_pct = 64;
			end else if (p < 6) begin
				send_idle_pct = 64;
				stall_pct = 33;
			end else begin
				send_idle_pct = 0;
				stall_pct = 0;
			end

			// long receiver hold while the sender keeps offering
			if (p == 1)
				hold_req <= 1'b1;

			burst_items = 0;
			while (burst_items < ITEMS_PER_PHASE) begin
				if ($urandom_range(3) == 0)
					queue_noise();
				else
					queue_touch_burst();
			end
		end

		wait_drained();
		if (error_count == 0)
			$display("tb_touch_event_decoder_scaler: done, clean");
		else
			$display("tb_touch_event_decoder_scaler: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Event driver: takes the next request once the current one is taken
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid   <= 1'b0;
			event_kind  <= '0;
			event_value <= '0;
			pen_state   = 1'b0;
			raw_x_seen  = '0;
			raw_y_seen  = '0;
		end else begin
			if (evt_valid && !evt_stall)
				predict_touch(event_kind, event_value);
			if (!evt_valid || !evt_stall) begin
				if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_evt = pending_events.pop_front();
					evt_valid   <= 1'b1;
					event_kind  <= next_evt.kind;
					event_value <= next_evt.value;
				end else begin
					evt_valid <= 1'b0;
				end
			end
		end
	end

	// predictor copy of the calibration registers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_x_min  <= teds_pkg::RST_X_MIN;
			cal_x_max  <= teds_pkg::RST_X_MAX;
			cal_y_min  <= teds_pkg::RST_Y_MIN;
			cal_y_max  <= teds_pkg::RST_Y_MAX;
			cal_width  <= teds_pkg::RST_WIDTH;
			cal_height <= teds_pkg::RST_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				teds_pkg::REG_X_MIN:  cal_x_min  <= cfg_data;
				teds_pkg::REG_X_MAX:  cal_x_max  <= cfg_data;
				teds_pkg::REG_Y_MIN:  cal_y_min  <= cfg_data;
				teds_pkg::REG_Y_MAX:  cal_y_max  <= cfg_data;
				teds_pkg::REG_WIDTH:  cal_width  <= cfg_data;
				teds_pkg::REG_HEIGHT: cal_height <= cfg_data;
				default: ;
			endcase
		end
	end

	// receiver hold-off counter, fires once on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_taken <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			hold_left  <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: in-order compare against predicted reports
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (reports_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result pen=%0b x=%0d y=%0d",
						pen_down, screen_x, screen_y));
				end else begin
					want = reports_due.pop_front();
					if (pen_down !== want.pen || screen_x !== want.x || screen_y !== want.y)
						report_mismatch($sformatf(
							"got pen=%0b x=%0d y=%0d, want pen=%0b x=%0d y=%0d",
							pen_down, screen_x, screen_y, want.pen, want.x, want.y));
				end
			end
			res_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog: nothing moved on any channel for too long
	always @(posedge clk) begin
		if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_touch_event_decoder_scaler: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

[filelist.f]
sv/teds_pkg.sv
sv/teds_dpath.sv
sv/teds_ctrl.sv
sv/touch_event_decoder_scaler.sv
test/tb_touch_event_decoder_scaler.sv
